>>> rtl/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTimeout   = 3'd1,
    StFrame     = 3'd2,
    StCrc       = 3'd3,
    StException = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CfgSlaveAddress     = 3'd0,
    CfgExpectedFunction = 3'd1,
    CfgExpectedCount    = 3'd2,
    CfgEchoAddress      = 3'd3,
    CfgEchoData         = 3'd4
  } cfg_idx_e;

  localparam logic [7:0]  FcReadHolding = 8'h03;
  localparam logic [7:0]  FcWriteSingle = 8'h06;
  localparam logic [7:0]  FcWriteMulti  = 8'h10;
  localparam logic [7:0]  ExcFlag       = 8'h80;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    status_e     status;
    logic [7:0]  exception_code;
    logic [6:0]  word_index;
    logic [15:0] word_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  expected_function;
    logic [6:0]  expected_count;
    logic [15:0] echo_address;
    logic [15:0] echo_data;
  } cfg_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [7:0]  slave_byte;
    logic [7:0]  function_byte;
    logic [7:0]  third_byte;
    logic [7:0]  pending_high;
    logic        echo_mismatch;
  } frame_t;

  // Reflected CRC-16 over one byte, eight shift steps.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/mrc_in_if.sv
`timescale 1ns / 1ps

interface mrc_in_if;
  logic              valid;
  logic              ready;
  mrc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mrc_out_if.sv
`timescale 1ns / 1ps

interface mrc_out_if;
  logic               valid;
  logic               ready;
  mrc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mrc_status_eval.sv
`timescale 1ns / 1ps

module mrc_status_eval #(
  parameter int MAX_FRAME = 256
) (
  input  mrc_pkg::cfg_t                      cfg_i,
  input  mrc_pkg::frame_t                    frame_i,
  input  logic [$clog2(MAX_FRAME + 2) - 1:0] count_i,
  output mrc_pkg::status_e                   status_o,
  output logic [7:0]                         exc_code_o
);
  import mrc_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME + 2);
  localparam int LenW = 10;

  logic [LenW-1:0] len_ext;
  logic [LenW-1:0] bytes_plus5;
  logic [7:0]      count_bytes;

  assign len_ext     = {{(LenW - CntW){1'b0}}, count_i};
  assign bytes_plus5 = {{(LenW - 8){1'b0}}, frame_i.third_byte} + LenW'(5);
  assign count_bytes = {cfg_i.expected_count, 1'b0};

  always_comb begin
    status_o   = StOk;
    exc_code_o = 8'h00;
    if (count_i == '0) begin
      status_o = StTimeout;
    end else if (count_i < CntW'(5) || count_i > CntW'(MAX_FRAME)) begin
      status_o = StFrame;
    end else if (frame_i.crc != 16'h0000) begin
      status_o = StCrc;
    end else if (frame_i.slave_byte != cfg_i.slave_address) begin
      status_o = StFrame;
    end else if (frame_i.function_byte == (cfg_i.expected_function | ExcFlag)) begin
      // The exception test wins even when the expected code already has bit 7 set.
      status_o   = StException;
      exc_code_o = frame_i.third_byte;
    end else if (frame_i.function_byte != cfg_i.expected_function) begin
      status_o = StFrame;
    end else if (cfg_i.expected_function == FcReadHolding) begin
      if (frame_i.third_byte != count_bytes || len_ext != bytes_plus5) begin
        status_o = StFrame;
      end
    end else if (cfg_i.expected_function == FcWriteSingle ||
                 cfg_i.expected_function == FcWriteMulti) begin
      if (count_i != CntW'(8) || frame_i.echo_mismatch) begin
        status_o = StFrame;
      end
    end
  end

endmodule

>>> rtl/modbus_rtu_response_checker_core.sv
`timescale 1ns / 1ps

// Modbus RTU response checker.
// Bytes of one response frame arrive on in_ch with kind 0; an item with kind 1
// marks the end of the frame. out_ch carries a provisional register word for
// each complete word of a read-holding response, and one final status per
// frame end; words are only to be trusted once an ok status follows.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i while
// the block is idle.
// Each transfer is held in an input register, evaluated there, and its result
// (if any) lands in the output register as the item leaves the input register.
// One item is taken every cycle unless a result waits for the output register;
// the CRC byte update and the status compare both sit in the single input stage.
// When the receiver stalls, items without a result still move on, and an item
// with a result waits in the input register until the output register frees,
// which then holds off new input. Reset clears the frame state (CRC to
// 0xFFFF, count and header bytes to zero) and loads the configuration
// defaults: slave 1, read holding, one register, zero echo values.
module modbus_rtu_response_checker_core #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrc_in_if.sink      in_ch,
  mrc_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mrc_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME + 2);
  localparam int CmpW = 10;
  localparam frame_t FrameIdle = '{crc: CrcInit, default: '0};

  cfg_t            cfg_q;
  frame_t          frame_q, frame_d;
  logic [CntW-1:0] count_q, count_d;

  logic            s1_valid_q;
  in_item_t        s1_item_q;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic            slot_free;
  logic            s1_adv;
  logic            has_result;
  out_item_t       result;
  status_e         fin_status;
  logic [7:0]      fin_exc;
  logic [CmpW-1:0] p_ext;
  logic [CmpW-1:0] idx;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address     <= 8'd1;
      cfg_q.expected_function <= FcReadHolding;
      cfg_q.expected_count    <= 7'd1;
      cfg_q.echo_address      <= 16'h0000;
      cfg_q.echo_data         <= 16'h0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSlaveAddress:     cfg_q.slave_address     <= cfg_data_i[7:0];
        CfgExpectedFunction: cfg_q.expected_function <= cfg_data_i[7:0];
        CfgExpectedCount:    cfg_q.expected_count    <= cfg_data_i[6:0];
        CfgEchoAddress:      cfg_q.echo_address      <= cfg_data_i;
        CfgEchoData:         cfg_q.echo_data         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrc_status_eval #(
    .MAX_FRAME (MAX_FRAME)
  ) u_status_eval (
    .cfg_i      (cfg_q),
    .frame_i    (frame_q),
    .count_i    (count_q),
    .status_o   (fin_status),
    .exc_code_o (fin_exc)
  );

  assign p_ext = {{(CmpW - CntW){1'b0}}, count_q};
  assign idx   = (p_ext - CmpW'(4)) >> 1;

  // Evaluation of the item in the input register.
  always_comb begin
    frame_d    = frame_q;
    count_d    = count_q;
    has_result = 1'b0;
    result     = '0;
    if (s1_item_q.kind) begin
      has_result            = 1'b1;
      result.result_kind    = 1'b1;
      result.status         = fin_status;
      result.exception_code = fin_exc;
      frame_d               = '0;
      frame_d.crc           = CrcInit;
      count_d               = '0;
    end else if (count_q >= CntW'(MAX_FRAME)) begin
      // Overlong frame: only count, saturating one past the limit.
      count_d = CntW'(MAX_FRAME + 1);
    end else begin
      count_d     = count_q + CntW'(1);
      frame_d.crc = crc16_byte(frame_q.crc, s1_item_q.rx_byte);
      if (count_q == CntW'(0)) frame_d.slave_byte    = s1_item_q.rx_byte;
      if (count_q == CntW'(1)) frame_d.function_byte = s1_item_q.rx_byte;
      if (count_q == CntW'(2)) frame_d.third_byte    = s1_item_q.rx_byte;
      if ((count_q == CntW'(2) && s1_item_q.rx_byte != cfg_q.echo_address[15:8]) ||
          (count_q == CntW'(3) && s1_item_q.rx_byte != cfg_q.echo_address[7:0]) ||
          (count_q == CntW'(4) && s1_item_q.rx_byte != cfg_q.echo_data[15:8]) ||
          (count_q == CntW'(5) && s1_item_q.rx_byte != cfg_q.echo_data[7:0])) begin
        frame_d.echo_mismatch = 1'b1;
      end
      if (count_q >= CntW'(3)) begin
        if (count_q[0]) begin
          frame_d.pending_high = s1_item_q.rx_byte;
        end else if (cfg_q.expected_function == FcReadHolding &&
                     frame_q.function_byte == FcReadHolding &&
                     idx < {{(CmpW - 7){1'b0}}, cfg_q.expected_count}) begin
          has_result        = 1'b1;
          result.word_index = idx[6:0];
          result.word_value = {frame_q.pending_high, s1_item_q.rx_byte};
        end
      end
    end
  end

  assign slot_free   = !out_valid_q || out_ch.ready;
  assign s1_adv      = s1_valid_q && (!has_result || slot_free);
  assign in_ch.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      count_q       <= '0;
      frame_q       <= FrameIdle;
    end else begin
      if (in_ch.ready) begin
        s1_valid_q <= in_ch.valid;
      end
      if (slot_free) begin
        out_valid_q <= s1_adv && has_result;
      end
      if (s1_adv) begin
        count_q <= count_d;
        frame_q <= frame_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_q <= in_ch.data;
    end
    if (s1_adv && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_item_q;

endmodule

>>> tb/sv/mrc_reply_checker.sv
`timescale 1ns / 1ps

module mrc_reply_checker #(
  parameter int MaxFrame = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrc_in_if           in_ch,
  mrc_out_if          out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          backlog_o
);
  import mrc_pkg::*;

  cfg_t        regs;
  int unsigned rx_len;
  logic [15:0] crc_acc;
  logic [7:0]  hdr_slave;
  logic [7:0]  hdr_func;
  logic [7:0]  hdr_third;
  logic [7:0]  word_high;
  logic        echo_bad;
  out_item_t   awaited_q[$];
  out_item_t   want;
  out_item_t   got;
  int          mismatches;

  // Bit-serial form of the reflected CRC: each data bit is folded into the
  // feedback test instead of being XORed into the register up front.
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic void clear_frame();
    rx_len    = 0;
    crc_acc   = CrcInit;
    hdr_slave = '0;
    hdr_func  = '0;
    hdr_third = '0;
    word_high = '0;
    echo_bad  = 1'b0;
  endfunction

  function automatic status_e frame_verdict(output logic [7:0] code);
    code = '0;
    if (rx_len == 0) return StTimeout;
    if (rx_len < 5 || rx_len > MaxFrame) return StFrame;
    if (crc_acc != '0) return StCrc;
    if (hdr_slave != regs.slave_address) return StFrame;
    // The exception form is tested first, so it wins when the requested
    // function code already carries the top bit.
    if (hdr_func == (regs.expected_function | ExcFlag)) begin
      code = hdr_third;
      return StException;
    end
    if (hdr_func != regs.expected_function) return StFrame;
    if (regs.expected_function == FcReadHolding) begin
      if (hdr_third != {regs.expected_count, 1'b0} || rx_len != hdr_third + 5) begin
        return StFrame;
      end
    end else if (regs.expected_function == FcWriteSingle ||
                 regs.expected_function == FcWriteMulti) begin
      if (rx_len != 8 || echo_bad) return StFrame;
    end
    return StOk;
  endfunction

  task automatic absorb_item(in_item_t it);
    out_item_t   r;
    logic [7:0]  code;
    logic [7:0]  b;
    int unsigned p;
    int unsigned idx;
    r = '0;
    b = it.rx_byte;
    p = rx_len;
    if (it.kind) begin
      r.result_kind    = 1'b1;
      r.status         = frame_verdict(code);
      r.exception_code = code;
      awaited_q.push_back(r);
      clear_frame();
    end else if (p >= MaxFrame) begin
      // Bytes past the longest frame are only counted.
      rx_len = MaxFrame + 1;
    end else begin
      rx_len  = p + 1;
      crc_acc = crc_step(crc_acc, b);
      case (p)
        0: hdr_slave = b;
        1: hdr_func = b;
        2: begin
          hdr_third = b;
          if (b != regs.echo_address[15:8]) echo_bad = 1'b1;
        end
        3: if (b != regs.echo_address[7:0]) echo_bad = 1'b1;
        4: if (b != regs.echo_data[15:8]) echo_bad = 1'b1;
        5: if (b != regs.echo_data[7:0]) echo_bad = 1'b1;
        default: ;
      endcase
      if (p >= 3) begin
        if (p % 2 == 1) begin
          word_high = b;
        end else begin
          idx = (p - 4) / 2;
          if (regs.expected_function == FcReadHolding && hdr_func == FcReadHolding &&
              idx < regs.expected_count) begin
            r.word_index = idx[6:0];
            r.word_value = {word_high, b};
            awaited_q.push_back(r);
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{slave_address: 8'd1, expected_function: FcReadHolding,
               expected_count: 7'd1, echo_address: 16'h0000, echo_data: 16'h0000};
      clear_frame();
      awaited_q.delete();
      mismatches = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = out_ch.data;
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing awaited: kind %0d status %0d exc %02h idx %0d word %04h",
                   $time, got.result_kind, got.status, got.exception_code,
                   got.word_index, got.word_value);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (got.result_kind !== want.result_kind || got.status !== want.status ||
              got.exception_code !== want.exception_code ||
              got.word_index !== want.word_index || got.word_value !== want.word_value) begin
            $display("%0t: expected kind %0d status %0d exc %02h idx %0d word %04h",
                     $time, want.result_kind, want.status, want.exception_code,
                     want.word_index, want.word_value);
            $display("%0t:   actual kind %0d status %0d exc %02h idx %0d word %04h",
                     $time, got.result_kind, got.status, got.exception_code,
                     got.word_index, got.word_value);
            mismatches++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        absorb_item(in_ch.data);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSlaveAddress:     regs.slave_address = cfg_data_i[7:0];
          CfgExpectedFunction: regs.expected_function = cfg_data_i[7:0];
          CfgExpectedCount:    regs.expected_count = cfg_data_i[6:0];
          CfgEchoAddress:      regs.echo_address = cfg_data_i;
          CfgEchoData:         regs.echo_data = cfg_data_i;
          default: ;
        endcase
      end
    end
    backlog_o        <= awaited_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

>>> tb/sv/modbus_rtu_response_checker_core_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_response_checker_core_tb;
  import mrc_pkg::*;

  localparam int RandomItems = 2000;
  localparam int QuietAfter  = 1700;
  localparam int LongHold    = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  int          mismatches;
  int          backlog;

  mrc_in_if  in_ch ();
  mrc_out_if out_ch ();

  modbus_rtu_response_checker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  mrc_reply_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .backlog_o        (backlog)
  );

  bit          tx_gaps;
  bit          rx_stalls;
  bit          hold_off_req;
  int          items_sent;
  logic [7:0]  frame_q[$];
  logic [7:0]  cur_slave;
  logic [7:0]  cur_func;
  logic [6:0]  cur_count;
  logic [15:0] cur_echo_addr;
  logic [15:0] cur_echo_data;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL modbus_rtu_response_checker_core");
    $finish;
  end

  // Receiver: random stall bursts, and one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // The CRC goes out low byte first, so a clean frame leaves a zero residue.
  function automatic void seal_frame();
    logic [15:0] c;
    c = CrcInit;
    foreach (frame_q[i]) c = crc16_byte(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endfunction

  function automatic void reply_body();
    frame_q.delete();
    frame_q.push_back(cur_slave);
    frame_q.push_back(cur_func);
    if (cur_func == FcReadHolding) begin
      frame_q.push_back({cur_count, 1'b0});
      repeat (2 * cur_count) frame_q.push_back(pick_byte());
    end else if (cur_func == FcWriteSingle || cur_func == FcWriteMulti) begin
      frame_q.push_back(cur_echo_addr[15:8]);
      frame_q.push_back(cur_echo_addr[7:0]);
      frame_q.push_back(cur_echo_data[15:8]);
      frame_q.push_back(cur_echo_data[7:0]);
    end else begin
      repeat ($urandom_range(1, 20)) frame_q.push_back(pick_byte());
    end
  endfunction

  task automatic put_item(input logic k, input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{kind: k, rx_byte: b};
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) put_item(1'b0, frame_q[i]);
    put_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic load_config(input int ph);
    case (ph)
      0: begin
        cur_slave = 8'd247; cur_func = FcReadHolding; cur_count = 7'd125;
        cur_echo_addr = 16'hFFFF; cur_echo_data = 16'hFFFF;
      end
      1: begin
        cur_slave = 8'd1; cur_func = FcWriteSingle; cur_count = 7'd1;
        cur_echo_addr = 16'h0000; cur_echo_data = 16'h0000;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       cur_slave = 8'd1;
          1:       cur_slave = 8'd247;
          default: cur_slave = 8'($urandom_range(1, 247));
        endcase
        case ($urandom_range(0, 7))
          3:       cur_func = FcWriteSingle;
          4:       cur_func = FcWriteMulti;
          5:       cur_func = FcReadHolding | ExcFlag;
          6:       cur_func = FcWriteSingle | ExcFlag;
          7:       cur_func = 8'($urandom_range(0, 255));
          default: cur_func = FcReadHolding;
        endcase
        if (ph == 2) cur_func = FcWriteMulti;
        if ($urandom_range(0, 7) == 0) begin
          cur_count = $urandom_range(0, 1) ? 7'd125 : 7'($urandom_range(1, 125));
        end else begin
          cur_count = 7'($urandom_range(1, 8));
        end
        cur_echo_addr = pick_word();
        cur_echo_data = pick_word();
      end
    endcase
    write_reg(CfgSlaveAddress, {8'h00, cur_slave});
    write_reg(CfgExpectedFunction, {8'h00, cur_func});
    write_reg(CfgExpectedCount, {9'h000, cur_count});
    write_reg(CfgEchoAddress, cur_echo_addr);
    write_reg(CfgEchoData, cur_echo_data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic long_frame();
    int len;
    case ($urandom_range(0, 4))
      0:       len = 255;
      1:       len = 256;
      2:       len = 257;
      3:       len = 258;
      default: len = 290;
    endcase
    frame_q.delete();
    frame_q.push_back(cur_slave);
    frame_q.push_back(cur_func);
    while (frame_q.size() < len - 2) frame_q.push_back(pick_byte());
    seal_frame();
    send_frame();
  endtask

  // Just under half are well-formed replies (normal or exception) with random content;
  // the rest are damaged in one way each, empty, or plain line noise.
  task automatic run_frame();
    int r;
    int idx;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      reply_body();
      seal_frame();
    end else if (r < 48) begin
      frame_q.delete();
      frame_q.push_back(cur_slave);
      frame_q.push_back(cur_func | ExcFlag);
      frame_q.push_back(pick_byte());
      seal_frame();
    end else if (r < 58) begin
      reply_body();
      seal_frame();
      idx = $urandom_range(0, frame_q.size() - 1);
      frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
    end else if (r < 64) begin
      reply_body();
      frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
      seal_frame();
    end else if (r < 72) begin
      reply_body();
      case ($urandom_range(0, 3))
        0:       frame_q[1] = FcReadHolding;
        1:       frame_q[1] = FcWriteSingle;
        2:       frame_q[1] = FcWriteMulti;
        default: frame_q[1] = 8'($urandom_range(0, 255));
      endcase
      seal_frame();
    end else if (r < 84) begin
      reply_body();
      case ($urandom_range(0, 2))
        0: begin
          idx = $urandom_range(2, frame_q.size() - 1);
          frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
        end
        1:       frame_q.pop_back();
        default: frame_q.insert($urandom_range(2, frame_q.size() - 1), pick_byte());
      endcase
      seal_frame();
    end else if (r < 92) begin
      frame_q.delete();
      repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 95) begin
      frame_q.delete();
    end else begin
      frame_q.delete();
      repeat ($urandom_range(1, 4)) frame_q.push_back(pick_byte());
    end
    send_frame();
  endtask

  initial begin
    int base;
    int ph;
    int nframes;
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CfgSlaveAddress;
    cfg_data_i   <= '0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    cur_slave     = 8'd1;
    cur_func      = FcReadHolding;
    cur_count     = 7'd1;
    cur_echo_addr = 16'h0000;
    cur_echo_data = 16'h0000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed frames against the reset configuration.
    frame_q.delete();
    send_frame();
    frame_q = '{8'h00, 8'hFF, 8'h80};
    send_frame();
    frame_q = '{8'h01, FcReadHolding, 8'h02, 8'hFF, 8'hFF};
    seal_frame();
    send_frame();
    frame_q = '{8'h01, FcReadHolding | ExcFlag, 8'hFF};
    seal_frame();
    send_frame();
    frame_q = '{8'h01, FcReadHolding, 8'h02, 8'h00, 8'h00};
    seal_frame();
    frame_q[5] = frame_q[5] ^ 8'h01;
    send_frame();
    drain();

    base = items_sent;
    ph   = 0;
    while (items_sent - base < RandomItems) begin
      load_config(ph);
      tx_gaps   = (items_sent - base <= QuietAfter) && ($urandom_range(0, 3) != 0);
      rx_stalls = (items_sent - base <= QuietAfter) && ($urandom_range(0, 3) != 0);
      nframes = (cur_func == FcReadHolding && cur_count > 16) ? 2 : 12;
      for (int f = 0; f < nframes; f++) begin
        if (items_sent - base > QuietAfter) begin
          tx_gaps   = 1'b0;
          rx_stalls = 1'b0;
        end
        if (ph == 0 && f == 0) begin
          // A full-size read while the receiver holds off fills the block up.
          hold_off_req = 1'b1;
          reply_body();
          seal_frame();
          send_frame();
        end else if (ph % 8 == 3 && f == 0) begin
          long_frame();
        end else begin
          run_frame();
        end
      end
      drain();
      ph++;
    end

    if (mismatches == 0 && backlog == 0) begin
      $display("PASS modbus_rtu_response_checker_core");
    end else begin
      $display("FAIL modbus_rtu_response_checker_core");
    end
    $finish;
  end

endmodule
